>>> rtl/crc_checked_sequenced_chunk_receiver_defines.svh
// Assertion macros used by the chunk receiver RTL.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef CRC_CHECKED_SEQUENCED_CHUNK_RECEIVER_DEFINES_SVH
`define CRC_CHECKED_SEQUENCED_CHUNK_RECEIVER_DEFINES_SVH

// Check sampled on the rising edge, switched off while reset is asserted.
`define CCSCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check sampled on every rising edge, reset included.
`define CCSCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ccscr_pkg.sv
// Types and constants for the CRC-checked sequenced chunk receiver.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ccscr_pkg;

    // Operation codes of an input word
    localparam logic [1:0] OP_OFFER  = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Reply codes
    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_CANCEL = 2'd3;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // One input word as held in the input register
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] packet_seq;
        logic [15:0] packet_crc;
        logic        store_ok;
    } item_t;

    // Handshake between the input register and the decision stage
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

>>> rtl/crc_checked_sequenced_chunk_receiver.sv
// Top level of the CRC-checked sequenced chunk receiver: input register and ports.
// Depends on ccscr_pkg and ccscr_core (which uses ccscr_crc8).
`timescale 1ns / 1ps

// Receive side of a stop-and-wait firmware-image transfer.
//
// Input channel (in_valid / in_ready): one word per handshake, carrying op
// (offer, data byte, finish), data_byte, last_byte, packet_seq, packet_crc and
// store_ok. Data bytes run through CRC-16/CCITT-FALSE; on the last byte of a
// packet the sequence number and CRC are checked and an ack, or a cancel when
// the write failed, is produced. Offer and finish always reply; other bytes
// and the unused op code give no reply.
//
// Output channel (out_valid / out_ready): reply_kind and ack_next.
//
// A reply is presented once its word has left the input register and moved into
// the result register; that move waits while a pending reply is not taken.
// Throughput: one word per cycle while replies are taken, set by the byte-wide
// combinational CRC update and sequence compare.
// When the output stalls, a pending reply holds; the input register still takes
// one more word, and words that give no reply keep flowing.
// Reset clears the expected sequence to zero, the CRC to 0xFFFF and both valid
// flags; no word is lost or replayed across a stall.

module crc_checked_sequenced_chunk_receiver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] packet_seq,
    input  logic [15:0] packet_crc,
    input  logic        store_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  reply_kind,
    output logic [31:0] ack_next
);

    ccscr_pkg::item_t      item_reg;
    logic                  item_valid_reg;
    logic                  item_valid_next;
    ccscr_pkg::stage_ctl_t ctl;
    logic                  accept;

    // take a new word whenever the held one leaves this cycle, or none is held
    assign in_ready = !ctl.valid || ctl.advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        priority if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (ctl.advance)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op         <= op;
            item_reg.data_byte  <= data_byte;
            item_reg.last_byte  <= last_byte;
            item_reg.packet_seq <= packet_seq;
            item_reg.packet_crc <= packet_crc;
            item_reg.store_ok   <= store_ok;
        end
    end

    ccscr_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_reg),
        .item_valid (item_valid_reg),
        .ctl        (ctl),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reply_kind (reply_kind),
        .ack_next   (ack_next)
    );

endmodule

>>> rtl/ccscr_crc8.sv
// Byte-wide CRC-16/CCITT-FALSE update, MSB first, unrolled over eight bits.
// Depends on ccscr_pkg for the polynomial.
`timescale 1ns / 1ps

module ccscr_crc8
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] v;
        v = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((v & ccscr_pkg::CRC_TOP) != 16'h0000)
            begin
                v = {v[14:0], 1'b0} ^ ccscr_pkg::CRC_POLY;
            end
            else
            begin
                v = {v[14:0], 1'b0};
            end
        end
        crc_out = v;
    end

endmodule

>>> rtl/ccscr_core.sv
// Decision stage: sequence and CRC state, reply decision and result register.
// Depends on ccscr_pkg, ccscr_crc8 and the assertion macro header.
`timescale 1ns / 1ps
`include "crc_checked_sequenced_chunk_receiver_defines.svh"

module ccscr_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccscr_pkg::item_t     item,
    input  logic                 item_valid,
    output ccscr_pkg::stage_ctl_t ctl,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           reply_kind,
    output logic [31:0]          ack_next
);

    logic [31:0] exp_seq_reg;
    logic [31:0] exp_seq_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic [1:0]  kind_reg;
    logic [1:0]  kind_next;
    logic [31:0] ack_reg;
    logic [31:0] ack_next_val;

    logic [15:0] crc_upd;
    logic        is_offer;
    logic        is_data;
    logic        is_finish;
    logic        produces;
    logic        advance;
    logic [31:0] seq_inc;

    ccscr_crc8 u_crc8
    (
        .crc_in  (crc_reg),
        .data    (item.data_byte),
        .crc_out (crc_upd)
    );

    assign is_offer  = (item.op == ccscr_pkg::OP_OFFER);
    assign is_data   = (item.op == ccscr_pkg::OP_DATA);
    assign is_finish = (item.op == ccscr_pkg::OP_FINISH);
    assign produces  = item_valid && (is_offer || is_finish || (is_data && item.last_byte));
    // a word with no reply never waits on the output side
    assign advance   = item_valid && (!produces || !res_valid_reg || out_ready);
    assign seq_inc   = exp_seq_reg + 32'd1;

    assign ctl.valid   = item_valid;
    assign ctl.advance = advance;

    always_comb
    begin
        exp_seq_next = exp_seq_reg;
        crc_next     = crc_reg;
        kind_next    = ccscr_pkg::KIND_ACK;
        ack_next_val = 32'd0;
        if (is_offer)
        begin
            exp_seq_next = 32'd0;
            crc_next     = ccscr_pkg::CRC_INIT;
            kind_next    = item.store_ok ? ccscr_pkg::KIND_ACCEPT : ccscr_pkg::KIND_REJECT;
        end
        else if (is_finish)
        begin
            crc_next  = ccscr_pkg::CRC_INIT;
            kind_next = item.store_ok ? ccscr_pkg::KIND_ACCEPT : ccscr_pkg::KIND_CANCEL;
        end
        else if (is_data)
        begin
            if (!item.last_byte)
            begin
                crc_next = crc_upd;
            end
            else
            begin
                crc_next = ccscr_pkg::CRC_INIT;
                priority if (item.packet_seq != exp_seq_reg || item.packet_crc != crc_upd)
                begin
                    kind_next    = ccscr_pkg::KIND_ACK;
                    ack_next_val = exp_seq_reg;
                end
                else if (!item.store_ok)
                begin
                    kind_next = ccscr_pkg::KIND_CANCEL;
                end
                else
                begin
                    exp_seq_next = seq_inc;
                    kind_next    = ccscr_pkg::KIND_ACK;
                    ack_next_val = seq_inc;
                end
            end
        end
    end

    always_comb
    begin
        priority if (advance && produces)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_seq_reg   <= 32'd0;
            crc_reg       <= ccscr_pkg::CRC_INIT;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                exp_seq_reg <= exp_seq_next;
                crc_reg     <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produces)
        begin
            kind_reg <= kind_next;
            ack_reg  <= ack_next_val;
        end
    end

    assign out_valid  = res_valid_reg;
    assign reply_kind = kind_reg;
    assign ack_next   = ack_reg;

    `CCSCR_ASSERT(a_ack_only_on_ack, (res_valid_reg && kind_reg != ccscr_pkg::KIND_ACK) |-> (ack_reg == 32'd0), "ack_next set on a non-ack reply")
    `CCSCR_ASSERT(a_crc_restart, (advance && is_data && item.last_byte) |=> (crc_reg == ccscr_pkg::CRC_INIT), "CRC not restarted after last byte")
    `CCSCR_ASSERT(a_seq_step, !$stable(exp_seq_reg) |-> (exp_seq_reg == 32'd0 || exp_seq_reg == $past(exp_seq_reg) + 32'd1), "expected sequence moved by other than one")
    `CCSCR_ASSERT(a_no_overwrite, (res_valid_reg && !out_ready && produces) |-> !advance, "pending reply overwritten")
    `CCSCR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !res_valid_reg, "reply valid after reset")

endmodule
